// ----- src/assert_macros.svh -----
// Assertion macros shared by the box mean filter RTL.
// Depends on nothing; users supply clock and reset signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BMF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that, once seen, must be followed by another on the next edge.
`define BMF_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/bmf_pkg.sv -----
// Package of the RGBA box mean filter: geometry constants, state and lane types.
// Depends on nothing; used by every module of the block.
package bmf_pkg;

   localparam int RADIUS     = 1;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int CHANNELS   = 4;

   localparam int RING_ROWS = 2 * RADIUS + 2;
   localparam int RING_W    = $clog2(RING_ROWS);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ADDR_W    = $clog2(RING_ROWS * MAX_WIDTH);
   localparam int WIN       = 2 * RADIUS + 1;
   localparam int CNT_MAX   = WIN * WIN;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);
   localparam int SUM_W     = $clog2(CNT_MAX * 255 + 1);

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BYPASS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ADDR,
      ST_ACC,
      ST_DIV,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       acc;
      logic       div;
      logic [2:0] shift;
   } lane_ctl_type;

   function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] r);
      ring_inc = (r == RING_W'(RING_ROWS - 1)) ? '0 : r + RING_W'(1);
   endfunction

endpackage

// ----- src/bmf_line_store.sv -----
// Line store of the box mean filter: a ring of pixel rows, one write and one read port.
// Depends on bmf_pkg for its depth and address width.
module bmf_line_store import bmf_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [RING_ROWS * MAX_WIDTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bmf_lane.sv -----
// One channel lane: accumulates window bytes, then divides the sum by the pixel count.
// Depends on bmf_pkg for widths and the lane control struct.
module bmf_lane import bmf_pkg::*; (
   input  logic             clock,
   input  lane_ctl_type     ctl,
   input  logic [7:0]       chan,
   input  logic [CNT_W-1:0] count,
   output logic [7:0]       quot
);

   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [7:0]       quot_ff, quot_in;
   logic [SUM_W+7:0] trial;

   // Restoring division, one quotient bit per cycle from the top bit down.
   assign trial = (SUM_W + 8)'(count) << ctl.shift;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (ctl.clear) begin
         rem_in  = '0;
         quot_in = '0;
      end else if (ctl.acc) begin
         rem_in = rem_ff + SUM_W'(chan);
      end else if (ctl.div) begin
         if ({8'b0, rem_ff} >= trial) begin
            rem_in             = rem_ff - trial[SUM_W-1:0];
            quot_in[ctl.shift] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ----- src/rgba_box_mean_filter_core.sv -----
// Top level of the RGBA box mean filter: control sequencer, counters, output register.
// Depends on bmf_pkg, bmf_line_store, bmf_lane and assert_macros.svh.
//
//   channel | direction | transfer when          | payload
//   req     | in        | req_tvalid & tready   | tdata pixel, tuser kind
//   rsp     | out       | rsp_tvalid & tready   | tdata mean pixel and position, tlast
//   csr     | in        | csr_valid & csr_ready | csr_index, csr_data
//
// An input transfer that produces no result passes ST_IDLE and ST_CHECK only; one that
// produces a result walks ST_ADDR and ST_ACC per window pixel read (up to 9 at radius
// 1, one in bypass), then ST_DIV and ST_HOLD: the single read port of the line store
// needs both per pixel, and the four channel dividers resolve one quotient bit per cycle.
// Reset is synchronous and active high; it clears counters, restores the config registers.
// A result waits in the output register; a stall there holds the sequencer only when
// the next result is ready to load.
`include "assert_macros.svh"

module rgba_box_mean_filter_core import bmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // red_in, green_in, blue_in, alpha_in
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // red_out, green_out, blue_out, alpha_out, out_row,
                                   // out_col, two zero bits
   output logic        rsp_tlast,  // frame_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   // Configuration registers.
   logic [10:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic        bypass_ff, bypass_in;

   // Sequencer and counters.
   state_type         state_ff, state_in;
   logic [12:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [RING_W-1:0] in_ring_ff, in_ring_in;
   logic              in_full_ff, in_full_in;
   logic [11:0]       er_ff, er_in;
   logic [COL_W-1:0]  ec_ff, ec_in;
   logic [RING_W-1:0] emit_ring_ff, emit_ring_in;

   // Window walk.
   logic [11:0]       k_ff, k_in, r1_ff, r1_in;
   logic [RING_W-1:0] k_ring_ff, k_ring_in;
   logic [COL_W-1:0]  l_ff, l_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2:0]        step_ff, step_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_pix_ff, rsp_pix_in;
   logic [11:0]       rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [10:0]       w_eff;
   logic [12:0]       h_eff;
   logic [12:0]       last_r, r0;
   logic [10:0]       last_c, c0;
   logic [RING_W-1:0] r0_ring, d_rows;
   logic              win_ready;
   logic              req_take, rsp_take, load_rsp;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [31:0]       rd_data;
   lane_ctl_type      lane_ctl;
   logic [7:0]        lane_q [CHANNELS];
   logic [31:0]       mean_pix;

   // Out-of-range geometry is clamped to the supported range.
   assign w_eff = (width_ff == 11'd0) ? 11'd1 :
                  (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == 13'd0) ? 13'd1 :
                  (height_ff > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_ff;

   // Window bounds around the next output position, clipped at the borders.
   always_comb begin
      last_r = (13'(er_ff) + 13'(RADIUS) < h_eff - 13'd1) ? 13'(er_ff) + 13'(RADIUS)
                                                          : h_eff - 13'd1;
      last_c = (11'(ec_ff) + 11'(RADIUS) < w_eff - 11'd1) ? 11'(ec_ff) + 11'(RADIUS)
                                                          : w_eff - 11'd1;
      r0 = (er_ff >= 12'(RADIUS)) ? 13'(er_ff) - 13'(RADIUS) : 13'd0;
      c0 = (ec_ff >= COL_W'(RADIUS)) ? 11'(ec_ff) - 11'(RADIUS) : 11'd0;
      d_rows  = RING_W'(13'(er_ff) - r0);
      r0_ring = (emit_ring_ff >= d_rows) ? emit_ring_ff - d_rows
                                         : emit_ring_ff + RING_W'(RING_ROWS) - d_rows;
      // Every pixel of the window has arrived once the input is past its last pixel.
      win_ready = in_full_ff || (last_r < in_row_ff) ||
                  ((last_r == in_row_ff) && (last_c < 11'(in_col_ff)));
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign load_rsp   = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_CHECK;
         ST_CHECK: state_in = win_ready ? ST_ADDR : ST_IDLE;
         ST_ADDR:  state_in = ST_ACC;
         ST_ACC:   state_in = (l_ff == c1_ff && k_ff == r1_ff) ? ST_DIV : ST_ADDR;
         ST_DIV:   if (step_ff == 3'd0) state_in = ST_HOLD;
         ST_HOLD:  if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and counter updates.
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      bypass_in    = bypass_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_ring_in   = in_ring_ff;
      in_full_in   = in_full_ff;
      er_in        = er_ff;
      ec_in        = ec_ff;
      emit_ring_in = emit_ring_ff;
      k_in         = k_ff;
      k_ring_in    = k_ring_ff;
      l_in         = l_ff;
      c0_in        = c0_ff;
      r1_in        = r1_ff;
      c1_in        = c1_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_pix_in   = rsp_pix_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      lane_ctl     = '0;

      case (state_ff)
         ST_IDLE: begin
            // A data pixel after the whole frame has arrived acts as a drain tick.
            if (req_take && !req_tuser && !in_full_ff) begin
               wr_en = 1'b1;
               if (11'(in_col_ff) + 11'd1 >= w_eff) begin
                  in_col_in  = '0;
                  in_row_in  = in_row_ff + 13'd1;
                  in_ring_in = ring_inc(in_ring_ff);
                  if (in_row_ff + 13'd1 >= h_eff) in_full_in = 1'b1;
               end else begin
                  in_col_in = in_col_ff + COL_W'(1);
               end
            end
         end
         ST_CHECK: begin
            lane_ctl.clear = 1'b1;
            cnt_in         = '0;
            if (bypass_ff) begin
               // Bypass reads a window of the centre pixel alone.
               k_in      = er_ff;
               k_ring_in = emit_ring_ff;
               l_in      = ec_ff;
               c0_in     = ec_ff;
               r1_in     = er_ff;
               c1_in     = ec_ff;
            end else begin
               k_in      = r0[11:0];
               k_ring_in = r0_ring;
               l_in      = c0[COL_W-1:0];
               c0_in     = c0[COL_W-1:0];
               r1_in     = last_r[11:0];
               c1_in     = last_c[COL_W-1:0];
            end
         end
         ST_ADDR: begin
            rd_en = 1'b1;
         end
         ST_ACC: begin
            lane_ctl.acc = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            step_in      = 3'd7;
            if (l_ff == c1_ff) begin
               if (k_ff != r1_ff) begin
                  k_in      = k_ff + 12'd1;
                  k_ring_in = ring_inc(k_ring_ff);
                  l_in      = c0_ff;
               end
            end else begin
               l_in = l_ff + COL_W'(1);
            end
         end
         ST_DIV: begin
            lane_ctl.div   = 1'b1;
            lane_ctl.shift = step_ff;
            step_in        = step_ff - 3'd1;
         end
         ST_HOLD: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = mean_pix;
               rsp_row_in   = er_ff;
               rsp_col_in   = ec_ff;
               rsp_last_in  = 1'b0;
               if (11'(ec_ff) + 11'd1 >= w_eff) begin
                  ec_in        = '0;
                  er_in        = er_ff + 12'd1;
                  emit_ring_in = ring_inc(emit_ring_ff);
               end else begin
                  ec_in = ec_ff + COL_W'(1);
               end
               // The final output of the frame rearms every counter for the next one.
               if (13'(er_ff) == h_eff - 13'd1 && 11'(ec_ff) == w_eff - 11'd1) begin
                  rsp_last_in  = 1'b1;
                  in_row_in    = '0;
                  in_col_in    = '0;
                  in_ring_in   = '0;
                  in_full_in   = 1'b0;
                  er_in        = '0;
                  ec_in        = '0;
                  emit_ring_in = '0;
               end
            end
         end
         default: begin
         end
      endcase

      // Geometry writes drop the frame in progress.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH, CSR_HEIGHT: begin
               if (csr_index == CSR_WIDTH) width_in = csr_data[10:0];
               else height_in = csr_data;
               in_row_in    = '0;
               in_col_in    = '0;
               in_ring_in   = '0;
               in_full_in   = 1'b0;
               er_in        = '0;
               ec_in        = '0;
               emit_ring_in = '0;
            end
            CSR_BYPASS: bypass_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign wr_addr = ADDR_W'(in_ring_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);
   assign rd_addr = ADDR_W'(k_ring_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(l_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'(MAX_WIDTH);
         height_ff    <= 13'd1;
         bypass_ff    <= 1'b0;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_ring_ff   <= '0;
         in_full_ff   <= 1'b0;
         er_ff        <= '0;
         ec_ff        <= '0;
         emit_ring_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bypass_ff    <= bypass_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_ring_ff   <= in_ring_in;
         in_full_ff   <= in_full_in;
         er_ff        <= er_in;
         ec_ff        <= ec_in;
         emit_ring_ff <= emit_ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      k_ring_ff   <= k_ring_in;
      l_ff        <= l_in;
      c0_ff       <= c0_in;
      r1_ff       <= r1_in;
      c1_ff       <= c1_in;
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   bmf_line_store u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One lane per channel; the merge packs their quotients back into a pixel.
   for (genvar p = 0; p < CHANNELS; p++) begin : g_lane
      bmf_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .chan  (rd_data[8*p +: 8]),
         .count (cnt_ff),
         .quot  (lane_q[p])
      );
      assign mean_pix[8*p +: 8] = lane_q[p];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff, rsp_pix_ff};
   assign rsp_tlast  = rsp_last_ff;

   `BMF_ASSERT(a_div_count, (state_ff != ST_DIV) || (cnt_ff != '0), "divide by zero count")
   `BMF_ASSERT(a_col_range, 11'(in_col_ff) < w_eff, "input column past row width")
   `BMF_ASSERT_NEXT(a_acc_next, state_ff == ST_ACC,
                    (state_ff == ST_ADDR) || (state_ff == ST_DIV), "window walk broke")

endmodule

// ----- test/tb_rgba_box_mean_filter_core.sv -----
// Testbench of rgba_box_mean_filter_core: a directed table, the largest geometry, then
// random frames of random geometry, each result checked against a predictor or typed value.
// Depends on bmf_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_rgba_box_mean_filter_core import bmf_pkg::*;;

   // One output pixel as the block delivers it.
   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] row;
      logic [9:0]  col;
      logic        last;
   } mean_pix_type;

   typedef enum {OP_PIX, OP_DRAIN, OP_CSR} op_type;

   // A row of the directed table. When fixed is set, the expected result is the one
   // typed into the row instead of the predicted one.
   typedef struct {
      op_type       op;
      logic [1:0]   idx;
      logic [12:0]  data;
      logic [31:0]  pix;
      bit           fixed;
      mean_pix_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   rgba_box_mean_filter_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Expected output pixels, oldest first.
   mean_pix_type pending_means[$];
   int           mismatch_count;
   bit           quiet;          // no idling on either side in the closing part
   bit           frame_closed;   // set when the predictor emits the last pixel of a frame
   int           items_sent;
   plan_row_type plan[$];

   // Shadow of the filter: its line buffer, counters and registers.
   logic [31:0] shadow_lines [RING_ROWS][MAX_WIDTH];
   int unsigned in_row, in_col, out_row_cnt, out_col_cnt;
   bit          frame_in;
   logic [10:0] geo_width;
   logic [12:0] geo_height;
   logic        pass_thru;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int unsigned eff_width();
      if (geo_width == 0) return 1;
      if (geo_width > MAX_WIDTH) return MAX_WIDTH;
      return geo_width;
   endfunction

   function automatic int unsigned eff_height();
      if (geo_height == 0) return 1;
      if (geo_height > MAX_HEIGHT) return MAX_HEIGHT;
      return geo_height;
   endfunction

   task automatic clear_position();
      in_row = 0;
      in_col = 0;
      out_row_cnt = 0;
      out_col_cnt = 0;
      frame_in = 1'b0;
   endtask

   task automatic apply_register(input logic [1:0] idx, input logic [12:0] value);
      if (idx == CSR_WIDTH) begin
         geo_width = value[10:0];
         clear_position();
      end else if (idx == CSR_HEIGHT) begin
         geo_height = value;
         clear_position();
      end else if (idx == CSR_BYPASS) begin
         pass_thru = value[0];
      end
   endtask

   // Takes one input transfer into the shadow and says whether an output pixel
   // becomes due, and which.
   task automatic filter_step(input bit drain, input logic [31:0] pix,
                              output bit hit, output mean_pix_type res);
      int unsigned w, h, got, lr, lc, r0, c0, cnt;
      int unsigned sums [4];
      logic [31:0] word;
      w = eff_width();
      h = eff_height();
      hit = 1'b0;
      res = '{default: '0};
      // A data pixel after the whole frame has arrived only pushes outputs out.
      if (!drain && !frame_in) begin
         shadow_lines[in_row % RING_ROWS][in_col % MAX_WIDTH] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) frame_in = 1'b1;
         end
      end
      got = frame_in ? w * h : in_row * w + in_col;
      lr = (out_row_cnt + RADIUS < h - 1) ? out_row_cnt + RADIUS : h - 1;
      lc = (out_col_cnt + RADIUS < w - 1) ? out_col_cnt + RADIUS : w - 1;
      if (lr * w + lc >= got) return;
      hit = 1'b1;
      if (pass_thru) begin
         word = shadow_lines[out_row_cnt % RING_ROWS][out_col_cnt % MAX_WIDTH];
         {res.alpha, res.blue, res.green, res.red} = word;
      end else begin
         r0 = (out_row_cnt >= RADIUS) ? out_row_cnt - RADIUS : 0;
         c0 = (out_col_cnt >= RADIUS) ? out_col_cnt - RADIUS : 0;
         cnt = 0;
         sums = '{0, 0, 0, 0};
         for (int unsigned k = r0; k <= lr; k++) begin
            for (int unsigned l = c0; l <= lc; l++) begin
               word = shadow_lines[k % RING_ROWS][l % MAX_WIDTH];
               cnt++;
               for (int p = 0; p < 4; p++) sums[p] += word[8*p +: 8];
            end
         end
         res.red   = 8'(sums[0] / cnt);
         res.green = 8'(sums[1] / cnt);
         res.blue  = 8'(sums[2] / cnt);
         res.alpha = 8'(sums[3] / cnt);
      end
      res.row = 12'(out_row_cnt);
      res.col = 10'(out_col_cnt);
      res.last = 1'b0;
      out_col_cnt++;
      if (out_col_cnt >= w) begin
         out_col_cnt = 0;
         out_row_cnt++;
      end
      if (res.row == h - 1 && res.col == 10'(w - 1)) begin
         res.last = 1'b1;
         frame_closed = 1'b1;
         clear_position();
      end
   endtask

   // Drops the input valid and waits until every expected pixel is out, then lets
   // the block finish any transfer that produces nothing.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sends one pixel or drain tick, at times after a random gap. When fixed is set the
   // typed expectation replaces the predicted one.
   task automatic send_item(input bit drain, input logic [31:0] pix,
                            input bit fixed, input mean_pix_type want);
      int gap;
      bit hit;
      mean_pix_type res;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= drain;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      filter_step(drain, pix, hit, res);
      if (hit) pending_means.push_back(fixed ? want : res);
   endtask

   // Receiver: stalls in random bursts, none in the closing part.
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         n = $urandom_range(1, 17);
         if (quiet) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            @(negedge clock);
            rsp_tready <= ($urandom_range(0, 2) != 0);
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // Every output transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      mean_pix_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red   = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue  = rsp_tdata[23:16];
         got.alpha = rsp_tdata[31:24];
         got.row   = rsp_tdata[43:32];
         got.col   = rsp_tdata[53:44];
         got.last  = rsp_tlast;
         if (pending_means.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected output pixel r%0d c%0d", got.row, got.col);
         end else begin
            want = pending_means.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("expected %h%h%h%h r%0d c%0d l%0b got %h%h%h%h r%0d c%0d l%0b",
                           want.red, want.green, want.blue, want.alpha, want.row, want.col,
                           want.last, got.red, got.green, got.blue, got.alpha, got.row,
                           got.col, got.last);
            end
         end
      end
   end

   function automatic plan_row_type row_of(op_type op, logic [1:0] idx, logic [12:0] data,
                                           logic [31:0] pix, bit fixed, mean_pix_type want);
      plan_row_type r;
      r.op = op;
      r.idx = idx;
      r.data = data;
      r.pix = pix;
      r.fixed = fixed;
      r.want = want;
      return r;
   endfunction

   initial begin
      mean_pix_type none;
      int unsigned w, h, burst;
      bit drain;
      none = '{default: '0};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      quiet = 1'b0;
      mismatch_count = 0;
      items_sent = 0;
      geo_width = 11'd1024;
      geo_height = 13'd1;
      pass_thru = 1'b0;
      clear_position();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. After reset the frame is one row of 1024 pixels, so a lone
      // pixel yields nothing yet.
      plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, 32'h0000_0000, 0, none));
      // A one-pixel frame: the mean is the pixel itself, and it ends the frame.
      plan.push_back(row_of(OP_CSR, CSR_WIDTH, 13'd1, 0, 0, none));
      plan.push_back(row_of(OP_CSR, CSR_HEIGHT, 13'd1, 0, 0, none));
      plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, 32'hFFFF_FFFF, 1,
                            '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'd0, 10'd0, 1'b1}));
      // A drain tick with nothing pending gives no result.
      plan.push_back(row_of(OP_DRAIN, CSR_WIDTH, 0, 32'hFFFF_FFFF, 0, none));
      // Bypass copies the pixel through unchanged.
      plan.push_back(row_of(OP_CSR, CSR_BYPASS, 13'd1, 0, 0, none));
      plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, 32'h1234_5678, 1,
                            '{8'h78, 8'h56, 8'h34, 8'h12, 12'd0, 10'd0, 1'b1}));
      plan.push_back(row_of(OP_CSR, CSR_BYPASS, 13'h1FFE, 0, 0, none));
      // The unused register index is ignored.
      plan.push_back(row_of(OP_CSR, 2'd3, 13'h1FFF, 0, 0, none));
      // Two pixels in one row, height zero acting as one: both means are 127.
      plan.push_back(row_of(OP_CSR, CSR_WIDTH, 13'd2, 0, 0, none));
      plan.push_back(row_of(OP_CSR, CSR_HEIGHT, 13'd0, 0, 0, none));
      plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, 32'h0000_0000, 0, none));
      plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, 32'hFFFF_FFFF, 1,
                            '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 12'd0, 10'd0, 1'b0}));
      // The last output leaves on a data pixel that arrives after the frame end.
      plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, 32'hA5A5_A5A5, 1,
                            '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 12'd0, 10'd1, 1'b1}));
      // A 3x3 frame with extreme values, then drains.
      plan.push_back(row_of(OP_CSR, CSR_WIDTH, 13'd3, 0, 0, none));
      plan.push_back(row_of(OP_CSR, CSR_HEIGHT, 13'd3, 0, 0, none));
      for (int i = 0; i < 9; i++)
         plan.push_back(row_of(OP_PIX, CSR_WIDTH, 0, (i % 2) ? 32'hFFFF_FFFF : 32'h0, 0, none));
      for (int i = 0; i < 4; i++)
         plan.push_back(row_of(OP_DRAIN, CSR_WIDTH, 0, 32'h0, 0, none));

      foreach (plan[i]) begin
         if (plan[i].op == OP_CSR) write_register(plan[i].idx, plan[i].data);
         else send_item(plan[i].op == OP_DRAIN, plan[i].pix, plan[i].fixed, plan[i].want);
      end

      // Largest geometry, written with every data bit set: a full 1024-pixel row,
      // then a tall single-column frame dropped part way by a geometry write.
      write_register(CSR_WIDTH, 13'h1FFF);
      write_register(CSR_HEIGHT, 13'd1);
      frame_closed = 1'b0;
      while (!frame_closed) send_item(1'b0, $urandom(), 1'b0, none);
      write_register(CSR_WIDTH, 13'd1);
      write_register(CSR_HEIGHT, 13'h1FFF);
      repeat (40) send_item($urandom_range(0, 5) == 0, $urandom(), 1'b0, none);
      write_register(CSR_WIDTH, 13'd0);

      // Random frames: mostly whole frames with random pixels and a few drain ticks,
      // sometimes a frame cut short by a new geometry.
      while (items_sent < 1350) begin
         if (items_sent > 1250) quiet = 1'b1;
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 6);
         write_register(CSR_WIDTH, 13'(w));
         write_register(CSR_HEIGHT, 13'(h));
         if ($urandom_range(0, 2) == 0) write_register(CSR_BYPASS, 13'($urandom()));
         if ($urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_item($urandom_range(0, 4) == 0, $urandom(), 1'b0, none);
         end else begin
            repeat ($urandom_range(1, 2)) begin
               frame_closed = 1'b0;
               while (!frame_closed) begin
                  drain = ($urandom_range(0, 9) == 0);
                  send_item(drain, $urandom(), 1'b0, none);
               end
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && pending_means.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/bmf_pkg.sv
src/bmf_line_store.sv
src/bmf_lane.sv
src/rgba_box_mean_filter_core.sv
test/tb_rgba_box_mean_filter_core.sv
